### hdl/bgd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_pkg
// Types and constants for the button gesture detector: sample and result
// words, gesture state codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package bgd_pkg;

	// one pin sample
	typedef struct packed {
		logic        pin_level;
		logic [31:0] now_ms;
	} in_word_t;

	// event pulses for one sample
	typedef struct packed {
		logic click_pulse;
		logic double_click_pulse;
		logic long_start_pulse;
		logic during_long_pulse;
		logic long_stop_pulse;
		logic long_pressed;
	} out_word_t;

	// gesture state, one-hot
	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_HELD     = 5'b00010,
		ST_RELEASED = 5'b00100,
		ST_SECOND   = 5'b01000,
		ST_LONG     = 5'b10000
	} gesture_state_t;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] REG_CLICK_MS      = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_MS = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_MS   = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LOW    = 2'd3;

	// register reset values
	localparam logic [15:0] CLICK_MS_RST      = 16'd600;
	localparam logic [15:0] LONG_PRESS_MS_RST = 16'd1000;
	localparam logic [15:0] DEBOUNCE_MS_RST   = 16'd50;
	localparam logic        ACTIVE_LOW_RST    = 1'b1;

endpackage

### hdl/button_gesture_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_detector
// Single click, double click and long press detection on sampled pin words.
// ----------------------------------------------------------------------------
// Usage: each input word carries one raw pin sample and a millisecond time
// stamp (wrapping modulo 2^32). Every accepted word yields exactly one
// result word with click, double click, long-press start, during and stop
// pulses plus the current long-press level.
// Channels: in_valid/in_ready/in_data for samples, out_valid/out_ready/
// out_data for results, both valid/ready. Configuration is a plain write
// port (cfg_wr_en, cfg_index, cfg_data) with no wait; write it only while
// no sample is in flight.
// Pipeline: an accepted word sits in the input register, and its result
// is loaded into the output register, which drives out_valid, once that
// register is free or being drained by out_ready.
// Throughput: one word per cycle unless out_ready stalls; the gesture state
// is updated in the same cycle as the result, so the next word sees it.
// Stalls: while out_ready is low the result is held and one more word can
// wait in the input register; in_ready then drops until the output drains.
// Reset: clears the gesture state, press time, long-press flag and both
// registers' valid flags, and loads the register defaults (600, 1000, 50,
// active low).
// ----------------------------------------------------------------------------
module button_gesture_detector (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// sample channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  bgd_pkg::in_word_t                    in_data,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output bgd_pkg::out_word_t                   out_data,
	// configuration write port
	input  logic                                 cfg_wr_en,
	input  logic [bgd_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [bgd_pkg::CFG_DATA_W-1:0]       cfg_data
);

	// configuration registers
	logic [15:0] click_ms_q;
	logic [15:0] long_press_ms_q;
	logic [15:0] debounce_ms_q;
	logic        active_low_q;

	// gesture state
	bgd_pkg::gesture_state_t state_q, state_d;
	logic [31:0] press_time_q, press_time_d;
	logic        long_flag_q, long_flag_d;

	// pipeline registers
	logic               valid_s1;
	bgd_pkg::in_word_t  word_s1;
	logic               out_valid_q;
	bgd_pkg::out_word_t out_word_q;
	bgd_pkg::out_word_t res_d;

	logic        advance;
	logic        pressed;
	logic [31:0] elapsed;

	// handshake
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_word_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			click_ms_q      <= bgd_pkg::CLICK_MS_RST;
			long_press_ms_q <= bgd_pkg::LONG_PRESS_MS_RST;
			debounce_ms_q   <= bgd_pkg::DEBOUNCE_MS_RST;
			active_low_q    <= bgd_pkg::ACTIVE_LOW_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				bgd_pkg::REG_CLICK_MS:      click_ms_q      <= cfg_data;
				bgd_pkg::REG_LONG_PRESS_MS: long_press_ms_q <= cfg_data;
				bgd_pkg::REG_DEBOUNCE_MS:   debounce_ms_q   <= cfg_data;
				bgd_pkg::REG_ACTIVE_LOW:    active_low_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_data;
		end
	end

	// pressed level and elapsed time since press start
	assign pressed = active_low_q ? !word_s1.pin_level : word_s1.pin_level;
	assign elapsed = word_s1.now_ms - press_time_q;

	// gesture machine next state
	always_comb begin
		state_d      = state_q;
		press_time_d = press_time_q;
		long_flag_d  = long_flag_q;
		res_d        = '0;
		unique case (state_q)
			bgd_pkg::ST_HELD: begin
				if (!pressed && (elapsed < {16'd0, debounce_ms_q})) begin
					state_d = bgd_pkg::ST_IDLE;
				end else if (!pressed) begin
					state_d = bgd_pkg::ST_RELEASED;
				end else if (elapsed > {16'd0, long_press_ms_q}) begin
					long_flag_d             = 1'b1;
					res_d.long_start_pulse  = 1'b1;
					res_d.during_long_pulse = 1'b1;
					state_d                 = bgd_pkg::ST_LONG;
				end
			end
			bgd_pkg::ST_RELEASED: begin
				if (elapsed > {16'd0, click_ms_q}) begin
					res_d.click_pulse = 1'b1;
					state_d           = bgd_pkg::ST_IDLE;
				end else if (pressed) begin
					state_d = bgd_pkg::ST_SECOND;
				end
			end
			bgd_pkg::ST_SECOND: begin
				if (!pressed) begin
					res_d.double_click_pulse = 1'b1;
					state_d                  = bgd_pkg::ST_IDLE;
				end
			end
			bgd_pkg::ST_LONG: begin
				if (!pressed) begin
					long_flag_d           = 1'b0;
					res_d.long_stop_pulse = 1'b1;
					state_d               = bgd_pkg::ST_IDLE;
				end else begin
					long_flag_d             = 1'b1;
					res_d.during_long_pulse = 1'b1;
				end
			end
			default: begin
				state_d = bgd_pkg::ST_IDLE;
				if (pressed) begin
					state_d      = bgd_pkg::ST_HELD;
					press_time_d = word_s1.now_ms;
				end
			end
		endcase
		res_d.long_pressed = long_flag_d;
	end

	// state update, one step per processed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= bgd_pkg::ST_IDLE;
			press_time_q <= '0;
			long_flag_q  <= 1'b0;
		end else if (advance) begin
			state_q      <= state_d;
			press_time_q <= press_time_d;
			long_flag_q  <= long_flag_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_word_q <= res_d;
		end
	end

	// long flag is only set while in the long-press state
	a_flag_state: assert property (@(posedge clk) disable iff (!arst_n)
		long_flag_q |-> (state_q == bgd_pkg::ST_LONG))
		else $error("long flag set outside long-press state");

	// gesture events are mutually exclusive in one result
	a_events_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot0({out_word_q.click_pulse, out_word_q.double_click_pulse,
			out_word_q.long_start_pulse, out_word_q.long_stop_pulse}))
		else $error("more than one gesture event in a result");

	// long start always comes with during and a raised level
	a_start_during: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_word_q.long_start_pulse) |->
			(out_word_q.during_long_pulse && out_word_q.long_pressed))
		else $error("long start without during pulse");

	// long stop leaves the level low
	a_stop_level: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_word_q.long_stop_pulse) |-> !out_word_q.long_pressed)
		else $error("long stop with long-press level still high");

	// a processed word always lands in the output register
	a_advance_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed word lost");

endmodule
